// ----- rtl/bch_pkg.sv -----
// ============================================================================
// bch_pkg
// Shared types, constants and helper functions of the bech32 address encoder.
// ============================================================================
package bch_pkg;

  // Largest human-readable prefix the block supports.
  localparam int MAX_PREFIX_CHARS_DEF = 8;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 2'd1;

  localparam logic [63:0] PREFIX_CHARS_RST  = 64'd25442;
  localparam logic [3:0]  PREFIX_LENGTH_RST = 4'd2;

  // Checksum constants.
  localparam logic [29:0] XOR_BECH32  = 30'h0000_0001;
  localparam logic [29:0] XOR_BECH32M = 30'h2bc8_30a3;
  localparam logic [29:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [7:0]   SEP_CHAR = 8'h31;

  // Width of the left-aligned regrouping buffer: four leftover bits plus a byte.
  localparam int RG_W = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFX_HI,
    ST_PFX_LO,
    ST_VER,
    ST_DATA,
    ST_PAD,
    ST_ZERO,
    ST_CHK
  } seq_state_t;

  typedef struct packed {
    logic init;
    logic feed;
    logic fin;
    logic shift;
  } pm_ctl_t;

  typedef struct packed {
    logic load;
    logic take;
    logic clear;
  } rg_ctl_t;

  typedef struct packed {
    logic in_prog;
    logic idle;
  } seq_stat_t;

  // One step of the bech32 polymod: shift in a 5-bit symbol.
  function automatic logic [29:0] pm_step(logic [29:0] acc, logic [4:0] v);
    logic [29:0] r;
    r = {acc[24:0], v};
    for (int i = 0; i < 5; i++) begin
      if (acc[25+i]) begin
        r = r ^ GEN[i];
      end
    end
    return r;
  endfunction

  // Map a 5-bit symbol to its charset character.
  function automatic logic [7:0] sym2char(logic [4:0] sym);
    logic [4:0] idx;
    idx = 5'd31 - sym;
    return CHARSET[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/bch_polymod.sv -----
// ============================================================================
// bch_polymod
// Checksum accumulator: absorbs one 5-bit symbol per cycle while feed is asserted
// and then shifts the finished checksum out five bits at a time.
// ============================================================================
module bch_polymod
  import bch_pkg::*;
(
  input  logic        clk,
  input  pm_ctl_t     ctl,
  input  logic [4:0]  sym,
  input  logic        use_m,
  output logic [4:0]  top
);

  logic [29:0] acc_r;
  logic [29:0] acc_nxt;
  logic [29:0] stepped;

  always_comb begin
    stepped = pm_step(acc_r, sym);
    acc_nxt = acc_r;
    if (ctl.init) begin
      acc_nxt = 30'd1;
    end else if (ctl.feed) begin
      // The last zero feed also folds in the variant constant.
      acc_nxt = ctl.fin ? (stepped ^ (use_m ? XOR_BECH32M : XOR_BECH32)) : stepped;
    end else if (ctl.shift) begin
      acc_nxt = {acc_r[24:0], 5'd0};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign top = acc_r[29:25];

endmodule

// ----- rtl/bch_regroup.sv -----
// ============================================================================
// bch_regroup
// Byte to 5-bit regrouping: a left-aligned bit shift register that takes a
// byte behind the pending bits and hands out one symbol per cycle while take is asserted.
// ============================================================================
module bch_regroup
  import bch_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rg_ctl_t     ctl,
  input  logic [7:0]  data_byte,
  output logic [4:0]  sym,
  output logic [3:0]  count
);

  logic [RG_W-1:0] buf_r;
  logic [RG_W-1:0] buf_nxt;
  logic [3:0]      cnt_r;
  logic [3:0]      cnt_nxt;

  // Bits below the pending count are always zero, so a new byte is ORed in
  // right behind them and the padding symbol comes out zero-filled.
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      buf_nxt = '0;
      cnt_nxt = 4'd0;
    end else if (ctl.load) begin
      buf_nxt = buf_r | ({data_byte, 4'b0000} >> cnt_r);
      cnt_nxt = cnt_r + 4'd8;
    end else if (ctl.take) begin
      buf_nxt = {buf_r[RG_W-6:0], 5'd0};
      cnt_nxt = cnt_r - 4'd5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= 4'd0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign sym   = buf_r[RG_W-1:RG_W-5];
  assign count = cnt_r;

endmodule

// ----- rtl/bch_seq.sv -----
// ============================================================================
// bch_seq
// Address sequencer: walks prefix, separator, version, data, padding and
// checksum steps, one symbol or character per cycle while the output is not stalled.
// ============================================================================
module bch_seq
  import bch_pkg::*;
#(
  parameter int MAX_PREFIX_CHARS = MAX_PREFIX_CHARS_DEF,
  localparam int PFX_W = 8 * MAX_PREFIX_CHARS
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_last,
  input  logic [4:0]       in_version,
  input  logic [PFX_W-1:0] cfg_pfx,
  input  logic [3:0]       cfg_len,
  input  logic             emit_ok,
  input  logic [4:0]       rg_sym,
  input  logic [3:0]       rg_cnt,
  input  logic [4:0]       pm_top,
  output pm_ctl_t          pm_ctl,
  output logic [4:0]       pm_sym,
  output logic             pm_use_m,
  output rg_ctl_t          rg_ctl,
  output logic             emit_v,
  output logic [7:0]       emit_char,
  output logic             emit_last,
  output seq_stat_t        stat
);

  seq_state_t       state_r, state_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [PFX_W-1:0] pfx_r, pfx_nxt;
  logic [4:0]       ver_r, ver_nxt;
  logic             last_r, last_nxt;
  logic             inprog_r, inprog_nxt;

  logic [3:0] len_eff;
  logic       emitting;
  logic       adv;
  logic [3:0] rem;
  logic       pfx_done;

  assign len_eff  = (cfg_len > 4'(MAX_PREFIX_CHARS)) ? 4'(MAX_PREFIX_CHARS) : cfg_len;
  assign pfx_done = (cnt_r == len_eff);
  assign rem      = rg_cnt - 4'd5;
  assign emitting = (state_r == ST_PFX_LO) || (state_r == ST_VER) || (state_r == ST_DATA)
                 || (state_r == ST_PAD) || (state_r == ST_CHK);
  assign adv      = !emitting || emit_ok;

  // Next state and sequencer registers.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pfx_nxt    = pfx_r;
    ver_nxt    = ver_r;
    last_nxt   = last_r;
    inprog_nxt = inprog_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (!inprog_r) begin
            ver_nxt    = in_version;
            inprog_nxt = 1'b1;
            pfx_nxt    = cfg_pfx;
            cnt_nxt    = 4'd0;
            state_nxt  = ST_PFX_HI;
          end else begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_PFX_HI: begin
        if (pfx_done) begin
          state_nxt = ST_PFX_LO;
          cnt_nxt   = 4'd0;
          pfx_nxt   = cfg_pfx;
        end else begin
          pfx_nxt = pfx_r >> 8;
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_PFX_LO: begin
        if (adv) begin
          if (pfx_done) begin
            state_nxt = ST_VER;
          end else begin
            pfx_nxt = pfx_r >> 8;
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      ST_VER: begin
        if (adv) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (adv && rem < 4'd5) begin
          cnt_nxt = 4'd0;
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (rem != 4'd0) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_ZERO;
          end
        end
      end
      ST_PAD: begin
        if (adv) begin
          state_nxt = ST_ZERO;
          cnt_nxt   = 4'd0;
        end
      end
      ST_ZERO: begin
        if (cnt_r == 4'd5) begin
          state_nxt = ST_CHK;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_CHK: begin
        if (adv) begin
          if (cnt_r == 4'd5) begin
            state_nxt  = ST_IDLE;
            inprog_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath controls and the emitted character.
  always_comb begin
    in_ready  = 1'b0;
    pm_ctl    = '0;
    pm_sym    = 5'd0;
    rg_ctl    = '0;
    emit_v    = 1'b0;
    emit_char = 8'd0;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        rg_ctl.load = in_valid;
        pm_ctl.init = in_valid && !inprog_r;
      end
      ST_PFX_HI: begin
        pm_ctl.feed = 1'b1;
        pm_sym      = pfx_done ? 5'd0 : {2'b00, pfx_r[7:5]};
      end
      ST_PFX_LO: begin
        emit_v      = adv;
        emit_char   = pfx_done ? SEP_CHAR : pfx_r[7:0];
        pm_ctl.feed = adv && !pfx_done;
        pm_sym      = pfx_r[4:0];
      end
      ST_VER: begin
        emit_v      = adv;
        emit_char   = sym2char(ver_r);
        pm_ctl.feed = adv;
        pm_sym      = ver_r;
      end
      ST_DATA: begin
        emit_v      = adv;
        emit_char   = sym2char(rg_sym);
        pm_ctl.feed = adv;
        pm_sym      = rg_sym;
        rg_ctl.take = adv;
      end
      ST_PAD: begin
        emit_v       = adv;
        emit_char    = sym2char(rg_sym);
        pm_ctl.feed  = adv;
        pm_sym       = rg_sym;
        rg_ctl.clear = adv;
      end
      ST_ZERO: begin
        pm_ctl.feed = 1'b1;
        pm_ctl.fin  = (cnt_r == 4'd5);
      end
      ST_CHK: begin
        emit_v       = adv;
        emit_char    = sym2char(pm_top);
        emit_last    = (cnt_r == 4'd5);
        pm_ctl.shift = adv;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= 4'd0;
      inprog_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      inprog_r <= inprog_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pfx_r  <= pfx_nxt;
    ver_r  <= ver_nxt;
    last_r <= last_nxt;
  end

  assign pm_use_m     = (ver_r != 5'd0);
  assign stat.in_prog = inprog_r;
  assign stat.idle    = (state_r == ST_IDLE);

endmodule

// ----- rtl/bech32_address_encoder_core.sv -----
// ============================================================================
// bech32_address_encoder_core
// Streaming segwit address encoder (bech32 for version 0, bech32m otherwise).
// ============================================================================
//
// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  ----------------------------------
// in_      input      in_valid / in_ready   program_byte, last_byte, version
// out_     output     out_valid / out_ready address_char, last_char
// cfg_     input      cfg_we (no wait)      cfg_index, cfg_wdata
//
// The sequencer does one step per cycle unless a stalled output holds it: a
// byte in the middle of a program takes an accept step, then one per completed
// 5-bit symbol. The first byte adds the prefix steps (high parts, separator,
// low parts with their characters, the '1' and the version). The last byte
// adds an optional padding symbol, six zero feeds and six checksum characters.
// Reset is synchronous and active low and restores the default "bc" prefix.
// A full output register stalls only the character-producing steps.
// ============================================================================
module bech32_address_encoder_core
  import bch_pkg::*;
#(
  parameter int MAX_PREFIX_CHARS = MAX_PREFIX_CHARS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Witness program bytes.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_program_byte,
  input  logic                  in_last_byte,
  input  logic [4:0]            in_witness_version,
  // Address characters.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_address_char,
  output logic                  out_last_char,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PFX_W = 8 * MAX_PREFIX_CHARS;

  // Configuration registers. Only the bytes the block can use are stored.
  logic [PFX_W-1:0] pfx_chars_r;
  logic [3:0]       pfx_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_chars_r <= PREFIX_CHARS_RST[PFX_W-1:0];
      pfx_len_r   <= PREFIX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PREFIX_CHARS:  pfx_chars_r <= cfg_wdata[PFX_W-1:0];
        REG_PREFIX_LENGTH: pfx_len_r   <= cfg_wdata[3:0];
        default: begin
          pfx_len_r <= pfx_len_r;
        end
      endcase
    end
  end

  pm_ctl_t    pm_ctl;
  logic [4:0] pm_sym;
  logic       pm_use_m;
  logic [4:0] pm_top;
  rg_ctl_t    rg_ctl;
  logic [4:0] rg_sym;
  logic [3:0] rg_cnt;
  logic       emit_v;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       emit_ok;
  seq_stat_t  stat;

  // Output register: the sequencer may emit whenever this slot is free or is
  // being drained in the same cycle.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r;

  assign emit_ok = !out_valid_r || out_ready;

  bch_seq #(
    .MAX_PREFIX_CHARS(MAX_PREFIX_CHARS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_last    (in_last_byte),
    .in_version (in_witness_version),
    .cfg_pfx    (pfx_chars_r),
    .cfg_len    (pfx_len_r),
    .emit_ok    (emit_ok),
    .rg_sym     (rg_sym),
    .rg_cnt     (rg_cnt),
    .pm_top     (pm_top),
    .pm_ctl     (pm_ctl),
    .pm_sym     (pm_sym),
    .pm_use_m   (pm_use_m),
    .rg_ctl     (rg_ctl),
    .emit_v     (emit_v),
    .emit_char  (emit_char),
    .emit_last  (emit_last),
    .stat       (stat)
  );

  bch_regroup u_regroup (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rg_ctl),
    .data_byte (in_program_byte),
    .sym       (rg_sym),
    .count     (rg_cnt)
  );

  bch_polymod u_polymod (
    .clk   (clk),
    .ctl   (pm_ctl),
    .sym   (pm_sym),
    .use_m (pm_use_m),
    .top   (pm_top)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_v) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_v) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_address_char = out_char_r;
  assign out_last_char    = out_last_r;

  // A character is never produced into an occupied, stalled output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_v |-> (!out_valid_r || out_ready))
    else $error("character emitted while output register is stalled");

  // The regrouping buffer never holds more than four leftover bits plus a byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    rg_cnt <= 4'd12)
    else $error("regrouping buffer overflow");

  // The final checksum character closes the address.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_v && emit_last) |=> (!stat.in_prog && stat.idle))
    else $error("address still open after last character");

  // The first byte of an address always starts the prefix steps.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.in_prog) |=> (stat.in_prog && !in_ready))
    else $error("first byte did not open an address");

endmodule
